[hdl/tpsl_pkg.sv]
// ----------------------------------------------------------------------------
// tpsl_pkg
// shared widths, register indexes and types of the stereo two-pole low-pass
// ----------------------------------------------------------------------------
`default_nettype none

package tpsl_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 20;
    localparam int COEF_FRAC_BITS = 17;

    // product and accumulator widths, with headroom for five summed taps
    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH  = COEF_WIDTH + SAMPLE_WIDTH + 3;

    localparam int NUM_REGS        = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_FEED   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_FB_ONE = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_FB_TWO = CFG_INDEX_WIDTH'(2);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    typedef struct packed {
        coef_t feed;
        coef_t fb_one;
        coef_t fb_two;
    } coef_set_t;

endpackage

`default_nettype wire

[hdl/tpsl_if.sv]
// ----------------------------------------------------------------------------
// tpsl_in_if / tpsl_out_if
// valid/ready channels carrying one stereo sample word
// ----------------------------------------------------------------------------
`default_nettype none

interface tpsl_in_if import tpsl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;

    modport source  (output valid, output left_in, output right_in, input ready);
    modport sink    (input valid, input left_in, input right_in, output ready);
    modport monitor (input valid, input left_in, input right_in, input ready);
endinterface

interface tpsl_out_if import tpsl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source  (output valid, output left_out, output right_out, input ready);
    modport sink    (input valid, input left_out, input right_out, output ready);
    modport monitor (input valid, input left_out, input right_out, input ready);
endinterface

`default_nettype wire

[hdl/tpsl_chan.sv]
// ----------------------------------------------------------------------------
// tpsl_chan
// one channel of the biquad: sample history and the five-tap sum
// ----------------------------------------------------------------------------
`default_nettype none

module tpsl_chan import tpsl_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire coef_set_t coef,
    input  wire sample_t   x0,
    output      sample_t   y
);

    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] HALF_LSB =
        ACC_WIDTH'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    sample_t x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_WIDTH-1:0] p0, p1, p2, p3, p4;
    logic signed [ACC_WIDTH-1:0]  acc;
    logic signed [ACC_WIDTH-1:0]  scaled;

    always_comb
    begin
        p0 = PROD_WIDTH'(coef.feed) * PROD_WIDTH'(x0);
        p1 = PROD_WIDTH'(coef.feed) * PROD_WIDTH'(x1_reg);
        p2 = PROD_WIDTH'(coef.feed) * PROD_WIDTH'(x2_reg);
        p3 = PROD_WIDTH'(coef.fb_one) * PROD_WIDTH'(y1_reg);
        p4 = PROD_WIDTH'(coef.fb_two) * PROD_WIDTH'(y2_reg);
        acc = ACC_WIDTH'(p0) + (ACC_WIDTH'(p1) <<< 1) + ACC_WIDTH'(p2)
            - ACC_WIDTH'(p3) - ACC_WIDTH'(p4) + HALF_LSB;
        // floor division by the fraction scale
        scaled = acc >>> COEF_FRAC_BITS;
        if (scaled > SAT_HI)
        begin
            y = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (scaled < SAT_LO)
        begin
            y = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y = scaled[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (advance)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x0;
            y2_reg <= y1_reg;
            y1_reg <= y;
        end
    end

endmodule

`default_nettype wire

[hdl/two_pole_stereo_lowpass_top.sv]
// ----------------------------------------------------------------------------
// two_pole_stereo_lowpass_top
// stereo direct form I biquad low-pass with programmable coefficients
// ----------------------------------------------------------------------------
// usage
//   in_word carries one left and one right signed sample per word, out_word
//   returns the filtered pair, rounded half up and saturated to 16 bits
//   coefficients are signed Q3.17, written through cfg_we / cfg_index /
//   cfg_data while no word is in flight; index 0 feed-forward gain, 1 and 2
//   the feedback taps; other indexes are ignored
// data path
//   a word accepted is loaded into the input register; the five-tap sum
//   runs from that register into the output register when the word
//   advances, and the result is offered from the output register
// throughput
//   one word per cycle while out_word is not stalled, set by the feedback
//   loop through the output history of each channel
// reset
//   rst_n clears the coefficients, all four history pairs and both valid bits
// backpressure
//   when out_word stalls, the output register holds and the input register
//   still takes one more word; in_word.ready drops only with both full
// ----------------------------------------------------------------------------
`default_nettype none

module two_pole_stereo_lowpass_top import tpsl_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COEF_WIDTH-1:0]      cfg_data,
    tpsl_in_if.sink                         in_word,
    tpsl_out_if.source                      out_word
);

    // coefficient registers
    coef_set_t coef_reg;

    // input register stage
    logic    s1_valid_reg;
    sample_t left_s1_reg;
    sample_t right_s1_reg;

    // output register stage
    logic    out_valid_reg;
    sample_t left_out_reg;
    sample_t right_out_reg;

    logic    advance;
    logic    in_accept;
    sample_t left_y;
    sample_t right_y;

    // the input register moves on when the output register is free or drains
    assign advance   = s1_valid_reg && (!out_valid_reg || out_word.ready);
    assign in_word.ready = !s1_valid_reg || advance;
    assign in_accept = in_word.valid && in_word.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_FEED:   coef_reg.feed   <= cfg_data;
                REG_COEF_FB_ONE: coef_reg.fb_one <= cfg_data;
                REG_COEF_FB_TWO: coef_reg.fb_two <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_word.ready)
        begin
            s1_valid_reg <= in_word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_s1_reg  <= in_word.left_in;
            right_s1_reg <= in_word.right_in;
        end
    end

    // per-channel filters, history shifts when the word advances
    tpsl_chan u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .coef    (coef_reg),
        .x0      (left_s1_reg),
        .y       (left_y)
    );

    tpsl_chan u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .coef    (coef_reg),
        .x0      (right_s1_reg),
        .y       (right_y)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_word.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= right_y;
        end
    end

    assign out_word.valid     = out_valid_reg;
    assign out_word.left_out  = left_out_reg;
    assign out_word.right_out = right_out_reg;

endmodule

`default_nettype wire

[hdl/tpsl_checker.sv]
// ----------------------------------------------------------------------------
// tpsl_checker
// port-level checks of the two-stage word buffer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tpsl_checker import tpsl_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t left_out,
    input wire sample_t right_out
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(left_out) && $stable(right_out))
        else $error("stalled output word changed");

    // a result appears only for a word taken through the input register
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output word without an accepted input word");

    // input backpressure only while the output is stalled
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input not ready without an output stall");

    // a word taken during a stall fills the buffer
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid && in_ready |=>
            in_ready == out_ready)
        else $error("buffer did not fill under stall");

endmodule

bind two_pole_stereo_lowpass_top tpsl_checker u_tpsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .left_out  (out_word.left_out),
    .right_out (out_word.right_out)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo two-pole low-pass: a short table of
// directed words and register writes, then phases of random words under
// changing coefficients, each result checked against hand values or a fixed-point predictor
// ----------------------------------------------------------------------------
module tb_top;
    import tpsl_pkg::*;

    // run shape
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 4;     // margin after the last owed result is back
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 85;
    localparam int LONG_HOLD       = 120;   // receiver hold-off in the pressure phase
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_PRINTED     = 40;

    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;

    // register index that maps to nothing; writes to it must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(3);

    // coefficient values in Q3.17
    localparam coef_t COEF_ZERO = coef_t'(0);
    localparam coef_t COEF_ONE  = coef_t'(131072);
    localparam coef_t COEF_HALF = coef_t'(65536);
    localparam coef_t COEF_MAX  = coef_t'(20'h7FFFF);
    localparam coef_t COEF_MIN  = coef_t'(20'h80000);

    localparam sample_t SAMPLE_MAX = sample_t'(16'h7FFF);
    localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);
    localparam longint  SAT_HI     = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint  SAT_LO     = -SAT_HI - 1;

    typedef struct {
        sample_t left;
        sample_t right;
    } stereo_pair_t;

    // one row of the directed table: a register write, a word checked by the
    // predictor, or a word whose result is written out by hand
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_WORD,
        ROW_KNOWN
    } plan_kind_e;

    typedef struct {
        plan_kind_e                 kind;
        logic [CFG_INDEX_WIDTH-1:0] index;
        coef_t                      data;
        sample_t                    left;
        sample_t                    right;
        sample_t                    want_left;
        sample_t                    want_right;
    } plan_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEF_WIDTH-1:0]      cfg_data;

    tpsl_in_if  in_ch ();
    tpsl_out_if out_ch ();

    two_pole_stereo_lowpass_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_ch),
        .out_word  (out_ch)
    );

    // predictor copy of the coefficients and the per-channel history
    coef_t   filt_feed;
    coef_t   filt_fb_one;
    coef_t   filt_fb_two;
    sample_t x_hist [2][2];    // [channel][0 = one back, 1 = two back]
    sample_t y_hist [2][2];

    stereo_pair_t pending_pairs [$];    // filtered pairs still owed by the block
    int           fault_count;
    bit           idle_on;              // random gaps on both sides
    logic         long_hold_req;        // asks the receiver for one long hold-off
    sample_t      last_left;
    sample_t      last_right;
    plan_row_t    directed_plan [$];

    // clock: period 12
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // one biquad step on one channel: five taps, round half up, saturate,
    // then shift both histories (saturated value goes into the output history)
    function automatic sample_t filter_channel(int ch, sample_t x0);
        longint acc;
        longint y;
        acc = longint'(filt_feed) * longint'(x0)
            + 2 * longint'(filt_feed) * longint'(x_hist[ch][0])
            + longint'(filt_feed) * longint'(x_hist[ch][1])
            - longint'(filt_fb_one) * longint'(y_hist[ch][0])
            - longint'(filt_fb_two) * longint'(y_hist[ch][1]);
        acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;    // arithmetic shift is the floor
        if (y > SAT_HI)
            y = SAT_HI;
        if (y < SAT_LO)
            y = SAT_LO;
        x_hist[ch][1] = x_hist[ch][0];
        x_hist[ch][0] = x0;
        y_hist[ch][1] = y_hist[ch][0];
        y_hist[ch][0] = sample_t'(y);
        return sample_t'(y);
    endfunction

    function automatic stereo_pair_t filter_pair(sample_t l, sample_t r);
        stereo_pair_t p;
        p.left  = filter_channel(CH_LEFT, l);
        p.right = filter_channel(CH_RIGHT, r);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------------

    function automatic plan_row_t row_write(logic [CFG_INDEX_WIDTH-1:0] idx, coef_t val);
        plan_row_t row;
        row = '{ROW_WRITE, idx, val, '0, '0, '0, '0};
        return row;
    endfunction

    function automatic plan_row_t row_word(sample_t l, sample_t r);
        plan_row_t row;
        row = '{ROW_WORD, REG_COEF_FEED, COEF_ZERO, l, r, '0, '0};
        return row;
    endfunction

    function automatic plan_row_t row_known(sample_t l, sample_t r, sample_t wl, sample_t wr);
        plan_row_t row;
        row = '{ROW_KNOWN, REG_COEF_FEED, COEF_ZERO, l, r, wl, wr};
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t pick_sample(sample_t prev);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3: return sample_t'(int'($urandom_range(0, 128)) - 64);
            4, 5:    return prev;    // steady input lets the filter settle
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // register write while the filter is idle; the predictor copy follows
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input coef_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_COEF_FEED:   filt_feed   = val;
            REG_COEF_FB_ONE: filt_fb_one = val;
            REG_COEF_FB_TWO: filt_fb_two = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one word, wait for the handshake, then book its result
    task automatic send_word(input sample_t l, input sample_t r, input bit known,
                             input sample_t wl, input sample_t wr);
        int           gap;
        stereo_pair_t p;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // accepted at this edge; the predictor always runs to keep its history
        p = filter_pair(l, r);
        if (known)
        begin
            p.left  = wl;
            p.right = wr;
        end
        pending_pairs.push_back(p);
    endtask

    // stop offering and wait until every booked result has come back
    task automatic drain_filter();
        in_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: checks each result word and applies back-pressure
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        stereo_pair_t want;
        int           stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_pairs.size() == 0)
                    report_fault($sformatf("result word with none pending: %0d %0d",
                                           out_ch.left_out, out_ch.right_out));
                else
                begin
                    want = pending_pairs.pop_front();
                    if (out_ch.left_out !== want.left)
                        report_fault($sformatf("left_out got %0d want %0d",
                                               out_ch.left_out, want.left));
                    if (out_ch.right_out !== want.right)
                        report_fault($sformatf("right_out got %0d want %0d",
                                               out_ch.right_out, want.right));
                end
            end
            // hold-off counted here so the sender keeps offering meanwhile
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                stall_left    = LONG_HOLD;
                long_hold_req <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            out_ch.ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout with %0d result words outstanding", pending_pairs.size());
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t row;
        sample_t   l;
        sample_t   r;

        // everything known from time zero
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_COEF_FEED;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        long_hold_req  = 1'b0;
        fault_count    = 0;
        idle_on        = 1'b1;
        last_left      = '0;
        last_right     = '0;
        filt_feed      = COEF_ZERO;
        filt_fb_one    = COEF_ZERO;
        filt_fb_two    = COEF_ZERO;
        for (int ch = 0; ch < 2; ch++)
            for (int k = 0; k < 2; k++)
            begin
                x_hist[ch][k] = '0;
                y_hist[ch][k] = '0;
            end

        // directed part
        directed_plan = '{
            // all coefficients zero after reset: silence whatever comes in
            row_known(SAMPLE_MAX, SAMPLE_MIN, 0, 0),
            row_known(-1, 1, 0, 0),
            // write to an index with no register behind it changes nothing
            row_write(REG_UNUSED, COEF_MAX),
            row_known(12345, -12345, 0, 0),
            // unity feed-forward: x0 + 2*x1 + x2, full-scale input saturates
            row_write(REG_COEF_FEED, COEF_ONE),
            row_known(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN),
            row_known(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN),
            row_known(0, 0, SAMPLE_MAX, SAMPLE_MIN),
            row_known(0, 0, SAMPLE_MAX, SAMPLE_MIN),
            row_known(0, 0, 0, 0),
            row_known(0, 0, 0, 0),
            // half gain: exact halves round up, so +1 -> 1 and -1 -> 0
            row_write(REG_COEF_FEED, COEF_HALF),
            row_word(1, -1),
            row_word(0, 0),
            row_word(0, 0),
            // feedback only, extreme taps: runaway into saturation
            row_write(REG_COEF_FEED, COEF_ZERO),
            row_write(REG_COEF_FB_ONE, COEF_MIN),
            row_write(REG_COEF_FB_TWO, COEF_MAX),
            row_word(100, -100),
            row_word(0, 0),
            row_word(SAMPLE_MIN, SAMPLE_MAX),
            row_word(0, 0),
            // every coefficient at an extreme
            row_write(REG_COEF_FEED, COEF_MIN),
            row_write(REG_COEF_FB_ONE, COEF_MAX),
            row_write(REG_COEF_FB_TWO, COEF_MIN),
            row_word(SAMPLE_MAX, SAMPLE_MIN),
            row_word(SAMPLE_MIN, SAMPLE_MAX),
            row_word(0, -1),
            row_word(-1, 0),
            // a plausible low-pass, step response
            row_write(REG_COEF_FEED, coef_t'(2634)),
            row_write(REG_COEF_FB_ONE, coef_t'(-204603)),
            row_write(REG_COEF_FB_TWO, coef_t'(84069)),
            row_word(10000, -10000),
            row_word(10000, -10000),
            row_word(10000, -10000)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE)
            begin
                // coefficients change only with nothing in flight
                drain_filter();
                write_reg(row.index, row.data);
            end
            else
                send_word(row.left, row.right, row.kind == ROW_KNOWN,
                          row.want_left, row.want_right);
        end

        // random phases, each under its own coefficient set
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_filter();
            case (phase)
                0:
                begin
                    write_reg(REG_COEF_FEED, COEF_MAX);
                    write_reg(REG_COEF_FB_ONE, COEF_MAX);
                    write_reg(REG_COEF_FB_TWO, COEF_MAX);
                end
                1:
                begin
                    write_reg(REG_COEF_FEED, COEF_MIN);
                    write_reg(REG_COEF_FB_ONE, COEF_MIN);
                    write_reg(REG_COEF_FB_TWO, COEF_MIN);
                end
                default:
                begin
                    if (phase == 2 || phase == 5 || $urandom_range(0, 1) == 1)
                    begin
                        // stable-ish low-pass: small gain, b1 from -1 to near -2, b2 below 1
                        write_reg(REG_COEF_FEED, coef_t'($urandom_range(200, 8000)));
                        write_reg(REG_COEF_FB_ONE,
                                  coef_t'(-int'($urandom_range(131072, 255000))));
                        write_reg(REG_COEF_FB_TWO, coef_t'($urandom_range(40000, 124000)));
                    end
                    else
                    begin
                        write_reg(REG_COEF_FEED, coef_t'($urandom));
                        write_reg(REG_COEF_FB_ONE, coef_t'($urandom));
                        write_reg(REG_COEF_FB_TWO, coef_t'($urandom));
                    end
                end
            endcase
            // a stray write now and then must leave the filter alone
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, coef_t'($urandom));

            // phases 2 and 5 run with no idling, words back to back
            idle_on = !(phase == 2 || phase == 5);
            // pressure: receiver holds off while words keep coming, block fills up
            if (phase == 2)
                long_hold_req <= 1'b1;

            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                // sender pauses mid-phase until every owed result is back
                if (phase == 4 && i == WORDS_PER_PHASE / 2)
                    drain_filter();
                l = pick_sample(last_left);
                r = pick_sample(last_right);
                last_left  = l;
                last_right = r;
                send_word(l, r, 1'b0, '0, '0);
            end
        end

        drain_filter();

        if (fault_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
